// ===== hdl/sli_pkg.sv =====
// Shared types, codes and constants for the sorted list insert core.
package sli_pkg;

    // Default store depth and fixed field widths
    localparam int DEPTH_DEF = 32;
    localparam int CMD_W     = 2;
    localparam int VAL_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 5;
    localparam int CNT_W     = 6;
    localparam int MAX_RES   = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // Input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_ENTRY    = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_READ,
        S_SPIN,
        S_CLEAR
    } state_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INSERT,
        OP_DROP,
        OP_CLEAR,
        OP_EMPTY,
        OP_EMIT,
        OP_SPIN
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        logic   latch;
        dp_op_t op;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic full;
        logic empty;
        logic last_emit;
        logic rot_done;
    } dp_stat_t;

endpackage

// ===== hdl/sli_ctrl.sv =====
// Controller state machine for the sorted list insert core.
module sli_ctrl
    import sli_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  dp_stat_t             stat,
    output dp_cmd_t              cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.latch  = 1'b0;
        cmd.op     = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch = 1'b1;
                    case (cmd_t'(s_cmd))
                        CMD_INSERT: state_next = S_INSERT;
                        CMD_READ:   state_next = S_READ;
                        CMD_CLEAR:  state_next = S_CLEAR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_INSERT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = stat.full ? OP_DROP : OP_INSERT;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    if (stat.empty)
                    begin
                        cmd.op     = OP_EMPTY;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.op = OP_EMIT;
                        if (stat.last_emit)
                        begin
                            state_next = stat.rot_done ? S_IDLE : S_SPIN;
                        end
                    end
                end
            end
            S_SPIN:
            begin
                // finish rotating entries beyond the emitted limit
                cmd.op = OP_SPIN;
                if (stat.rot_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/sli_dp.sv =====
// Datapath: sorted cell row, count, read-out counter and output register.
module sli_dp
    import sli_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VAL_W-1:0]      s_value,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser,
    output logic                  m_tlast
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = $clog2(DEPTH);
    localparam int LW  = (CW > 7) ? CW : 7;

    logic signed [VAL_W-1:0] cell_reg [DEPTH];
    logic signed [VAL_W-1:0] cell_next [DEPTH];
    logic signed [VAL_W-1:0] val_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic [DEPTH-1:0]        gt;

    logic                    valid_reg, valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [VAL_W-1:0]        oval_reg, oval_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        ocnt_reg, ocnt_next;
    logic                    last_reg, last_next;

    logic [LW-1:0]           count_ext, lim, idx_inc;
    logic                    rotate, load;

    // Status toward the controller
    assign count_ext      = LW'(count_reg);
    assign lim            = (count_ext > LW'(MAX_RES)) ? LW'(MAX_RES) : count_ext;
    assign idx_inc        = LW'(idx_reg) + LW'(1);
    assign stat.out_free  = !valid_reg || m_tready;
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.last_emit = (idx_inc == lim);
    assign stat.rot_done  = (idx_inc == count_ext);

    assign rotate = (cmd.op == OP_EMIT) || (cmd.op == OP_SPIN);

    // Parallel compare: cells holding a value above the new one move up
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CW'(i) < count_reg) && (cell_reg[i] > val_reg);
        end
    end

    // Cell row next values: shift-insert or rotate-down within the count
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.op == OP_INSERT)
            begin
                if (gt[i] || (CW'(i) == count_reg))
                begin
                    if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                    begin
                        cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        cell_next[i] = val_reg;
                    end
                end
            end
            else if (rotate)
            begin
                if (CW'(i) + CW'(1) == count_reg)
                begin
                    cell_next[i] = cell_reg[0];
                end
                else if (CW'(i) + CW'(1) < count_reg)
                begin
                    cell_next[i] = cell_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    // Count, read index and result word
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        load        = 1'b0;
        status_next = status_reg;
        oval_next   = oval_reg;
        pos_next    = pos_reg;
        ocnt_next   = ocnt_reg;
        last_next   = last_reg;
        if (cmd.latch)
        begin
            idx_next = '0;
        end
        case (cmd.op)
            OP_INSERT:
            begin
                count_next  = count_reg + CW'(1);
                load        = 1'b1;
                status_next = ST_INSERTED;
                oval_next   = '0;
                pos_next    = '0;
                ocnt_next   = CNT_W'(count_reg + CW'(1));
                last_next   = 1'b1;
            end
            OP_DROP:
            begin
                load        = 1'b1;
                status_next = ST_DROPPED;
                oval_next   = '0;
                pos_next    = '0;
                ocnt_next   = CNT_W'(count_reg);
                last_next   = 1'b1;
            end
            OP_CLEAR:
            begin
                count_next  = '0;
                load        = 1'b1;
                status_next = ST_CLEARED;
                oval_next   = '0;
                pos_next    = '0;
                ocnt_next   = '0;
                last_next   = 1'b1;
            end
            OP_EMPTY:
            begin
                load        = 1'b1;
                status_next = ST_EMPTY;
                oval_next   = '0;
                pos_next    = '0;
                ocnt_next   = '0;
                last_next   = 1'b1;
            end
            OP_EMIT:
            begin
                idx_next    = idx_reg + IW'(1);
                load        = 1'b1;
                status_next = ST_ENTRY;
                oval_next   = cell_reg[0];
                pos_next    = POS_W'(idx_reg);
                ocnt_next   = CNT_W'(count_reg);
                last_next   = stat.last_emit;
            end
            OP_SPIN:
            begin
                idx_next = idx_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && !m_tready;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            val_reg <= s_value;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        status_reg <= status_next;
        oval_reg   <= oval_next;
        pos_reg    <= pos_next;
        ocnt_reg   <= ocnt_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, ocnt_reg, pos_reg, oval_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hdl/sorted_list_insert_core.sv =====
// Top level of the sorted list insert core.
//
// Holds up to DEPTH signed 32-bit values in ascending order in a row of
// registers. Each input word carries a command in s_tuser: insert places
// s_tdata after every held value less than or equal to it (duplicates kept)
// and answers with one word; when the store is full the value is dropped and
// flagged. Read-out emits every held entry smallest first (at most 32) with
// m_tlast on the final one, or a single empty marker; clear empties the store.
// Command code 3 is ignored and gives no word. An insert, drop or clear is
// accepted in the idle state and completed in the next state once the output
// register is free; for an insert all cells compare in parallel and shift there.
// Read-out emits one entry per cycle while the output is not stalled, by
// rotating the cell row down through position 0; with DEPTH above 32 and more
// than 32 entries held it then rotates the rest back into order. New input is
// accepted only when the previous command is finished, but a finished result
// may still be waiting in the output register.
module sorted_list_insert_core
    import sli_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] new_value
    input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] entry_value, [36:32] entry_position,
                                             // [42:37] entry_count, [47:43] zero
    output logic [STATUS_W-1:0]   m_tuser,   // [2:0] status
    output logic                  m_tlast    // last_result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller
    sli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    sli_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_value  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== bench/sorted_list_insert_core_test.sv =====
`timescale 1ns / 100ps
// Testbench for the sorted list insert core: directed and random command streams, checked word by word.
module sorted_list_insert_core_test;
    import sli_pkg::*;

    localparam int RANDOM_ITEMS  = 380;
    localparam int SETTLE_CYCLES = 48;
    localparam int MAX_REPORTS   = 10;

    // One output word, split into its fields
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    value;
        logic [POS_W-1:0]    position;
        logic [CNT_W-1:0]    count;
        logic                last;
    } list_word_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [CMD_W-1:0]      s_tuser  = CMD_NONE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    bit idling_on      = 1'b1;
    int mismatch_count = 0;
    int words_sent     = 0;

    // Shadow copy of the sorted store and the words it should produce
    logic signed [VAL_W-1:0] shadow_list[$];
    list_word_t              pending_words[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_list_insert_core #(
        .DEPTH (DEPTH_DEF)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic list_word_t make_word(status_t st, logic [VAL_W-1:0] v, int pos,
                                             int cnt, bit last);
        list_word_t w;
        w.status   = st;
        w.value    = v;
        w.position = pos[POS_W-1:0];
        w.count    = cnt[CNT_W-1:0];
        w.last     = last;
        return w;
    endfunction

    // Sorted-store predictor: updates the shadow list and queues the words it causes
    task automatic apply_command(cmd_t cmd, logic signed [VAL_W-1:0] v);
        int held;
        int slot;
        int emit_n;
        held = shadow_list.size();
        case (cmd)
            CMD_INSERT:
            begin
                if (held >= DEPTH_DEF)
                    pending_words.push_back(make_word(ST_DROPPED, '0, 0, held, 1'b1));
                else
                begin
                    // new value goes after every entry less than or equal to it
                    slot = 0;
                    while (slot < held && shadow_list[slot] <= v)
                        slot++;
                    shadow_list.insert(slot, v);
                    pending_words.push_back(make_word(ST_INSERTED, '0, 0, held + 1, 1'b1));
                end
            end
            CMD_READ:
            begin
                if (held == 0)
                    pending_words.push_back(make_word(ST_EMPTY, '0, 0, 0, 1'b1));
                else
                begin
                    emit_n = (held > MAX_RES) ? MAX_RES : held;
                    for (int k = 0; k < emit_n; k++)
                        pending_words.push_back(make_word(ST_ENTRY, shadow_list[k], k, held,
                                                          k == emit_n - 1));
                end
            end
            CMD_CLEAR:
            begin
                shadow_list.delete();
                pending_words.push_back(make_word(ST_CLEARED, '0, 0, 0, 1'b1));
            end
            default:
            begin
                // unused code: no word, no change
            end
        endcase
    endtask

    // Watch both handshakes: check each output word, predict on each accepted input word
    always @(posedge clk)
    begin : watch_words
        list_word_t want;
        list_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[31:0], m_tdata[36:32], m_tdata[42:37], m_tlast};
            if (pending_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected word: status %0d value %0d pos %0d count %0d last %0d",
                             got.status, $signed(got.value), got.position, got.count,
                             got.last);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("word mismatch (expected/actual): status %0d/%0d value %0d/%0d",
                                 want.status, got.status, $signed(want.value),
                                 $signed(got.value));
                        $display("    pos %0d/%0d count %0d/%0d last %0d/%0d",
                                 want.position, got.position, want.count, got.count,
                                 want.last, got.last);
                    end
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            apply_command(cmd_t'(s_tuser), s_tdata);
    end

    // Output side back-pressure
    always @(posedge clk)
        m_tready <= !(idling_on && $urandom_range(99) < 26);

    // Send one input word; valid stays high into the next word unless a gap is taken
    task automatic send_word(cmd_t cmd, logic [VAL_W-1:0] v);
        while (idling_on && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd != CMD_NONE)
            words_sent++;
    endtask

    // Values biased toward the extremes and a narrow band around zero for duplicates
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return $urandom_range(8) - 4;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_empty_store();
        send_word(CMD_READ, $urandom());
        send_word(CMD_NONE, $urandom());
        send_word(CMD_CLEAR, $urandom());
        send_word(CMD_READ, 32'hffff_ffff);
    endtask

    task automatic test_extremes_and_duplicates();
        send_word(CMD_INSERT, 32'h7fff_ffff);
        send_word(CMD_INSERT, 32'h8000_0000);
        send_word(CMD_INSERT, 32'h0000_0000);
        send_word(CMD_INSERT, 32'hffff_ffff);
        send_word(CMD_INSERT, 32'h0000_0001);
        // repeats of the head, the tail and a middle entry are all kept
        send_word(CMD_INSERT, 32'h8000_0000);
        send_word(CMD_INSERT, 32'h7fff_ffff);
        send_word(CMD_INSERT, 32'h0000_0000);
        send_word(CMD_READ, 32'h0000_0000);
        send_word(CMD_NONE, 32'hffff_ffff);
        send_word(CMD_READ, 32'hffff_ffff);
    endtask

    task automatic test_clear_between();
        send_word(CMD_CLEAR, 32'h0000_0000);
        send_word(CMD_READ, $urandom());
        send_word(CMD_INSERT, 32'h0000_0005);
        send_word(CMD_READ, $urandom());
        send_word(CMD_CLEAR, 32'hffff_ffff);
    endtask

    // Fill to the top and push past it, with no idling on either side
    task automatic test_full_store();
        idling_on = 1'b0;
        send_word(CMD_CLEAR, $urandom());
        repeat (DEPTH_DEF)
            send_word(CMD_INSERT, pick_value());
        send_word(CMD_INSERT, pick_value());
        send_word(CMD_INSERT, 32'h7fff_ffff);
        send_word(CMD_READ, $urandom());
        send_word(CMD_NONE, $urandom());
        send_word(CMD_READ, $urandom());
        send_word(CMD_CLEAR, $urandom());
        idling_on = 1'b1;
    endtask

    // Runs of inserts with random content, mixed with reads, stray clears and unused codes
    task automatic test_random_traffic();
        int start_count;
        int fill;
        int pick;
        start_count = words_sent;
        while (words_sent - start_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(3) != 0)
                send_word(CMD_CLEAR, $urandom());
            fill = $urandom_range(36);
            repeat (fill)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    send_word(CMD_READ, $urandom());
                else if (pick < 11)
                    send_word(CMD_NONE, $urandom());
                else if (pick < 13)
                    send_word(CMD_CLEAR, $urandom());
                else
                    send_word(CMD_INSERT, pick_value());
            end
            send_word(CMD_READ, $urandom());
        end
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        test_empty_store();
        test_extremes_and_duplicates();
        test_clear_between();
        test_full_store();
        test_random_traffic();
        s_tvalid <= 1'b0;
        // drain, then allow for a trailing read-out
        do
            @(posedge clk);
        while (pending_words.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("sorted_list_insert_core_test: done, clean");
        else
            $display("sorted_list_insert_core_test: done, errors");
        $finish;
    end

    // Hang guard
    initial
    begin
        #5_000_000;
        $display("sorted_list_insert_core_test: done, errors");
        $finish;
    end

endmodule
